/* rtl/chtfq_pkg.sv */
package chtfq_pkg;

   localparam int DefBuckets  = 8;
   localparam int DefPoolSize = 64;

   localparam int OpWidth    = 3;
   localparam int EntryWidth = 6;
   localparam int KeyWidth   = 16;
   localparam int ResWidth   = 7;

   typedef enum logic [OpWidth-1:0] {
      OP_INS_TAIL = 3'd0,
      OP_INS_HEAD = 3'd1,
      OP_LOOKUP   = 3'd2,
      OP_DELETE   = 3'd3,
      OP_PUSH     = 3'd4,
      OP_POP      = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RD_KEY,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_DEL_RD,
      ST_DEL_FIX,
      ST_POP_RD,
      ST_DONE
   } state_type;

endpackage

/* rtl/chained_hash_table_with_free_queue_top.sv */
// Insert/push commit in ST_RD_KEY; pop reads the free-queue tail first; lookup walks the
// chain; delete reads the key, walks to the entry and unlinks it (single read port).
// Throughput: one word at a time; the next word is taken once the result is taken.
// Reset: synchronous; after reset a clearing pass writes null links and zero keys
// to all POOL_SIZE entries of the entry memories while no word is accepted.
module chained_hash_table_with_free_queue_top #(
   parameter int BUCKETS   = chtfq_pkg::DefBuckets,
   parameter int POOL_SIZE = chtfq_pkg::DefPoolSize
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [chtfq_pkg::OpWidth-1:0]      req_opcode,
   input  logic [chtfq_pkg::EntryWidth-1:0]   req_entry,
   input  logic [chtfq_pkg::KeyWidth-1:0]     req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_ok,
   output logic [chtfq_pkg::ResWidth-1:0]     rsp_result_entry
);
   import chtfq_pkg::*;

   localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int LW = $clog2(POOL_SIZE + 1);
   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

   // entry memories: key, next, prev
   logic [KeyWidth-1:0] key_mem  [POOL_SIZE];
   logic [LW-1:0]       next_mem [POOL_SIZE];
   logic [LW-1:0]       prev_mem [POOL_SIZE];

   // bucket table and free queue ends in flops
   logic [LW-1:0] bhead_ff [BUCKETS];
   logic [LW-1:0] btail_ff [BUCKETS];
   logic [LW-1:0] bcnt_ff  [BUCKETS];
   logic [LW-1:0] fhead_ff, ftail_ff;

   state_type state_ff, state_in;
   opcode_type op_ff;
   logic [LW-1:0] ent_ff;
   logic [KeyWidth-1:0] key_ff;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [LW-1:0] cur_ff, cur_in;
   logic [LW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0] clr_ff;
   logic ok_ff, ok_in;
   logic [LW-1:0] res_ff, res_in;

   // memory read port: one address, all three arrays
   logic [IW-1:0] rd_addr;
   logic [KeyWidth-1:0] rd_key;
   logic [LW-1:0] rd_next, rd_prev;

   // write ports
   logic key_we, nx_we, pv_we, nx2_we, pv2_we;
   logic [IW-1:0] key_wa, nx_wa, pv_wa, nx2_wa, pv2_wa;
   logic [KeyWidth-1:0] key_wd;
   logic [LW-1:0] nx_wd, pv_wd, nx2_wd, pv2_wd;

   function automatic logic vix(input logic [LW-1:0] e);
      return e < NIL;
   endfunction

   function automatic logic [BW-1:0] bsel(input logic [KeyWidth-1:0] k);
      return BW'(k % BUCKETS);
   endfunction

   // neighbor link writes first, so the own-entry write wins on a shared address
   always_ff @(posedge clock) begin
      rd_key  <= key_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
      rd_prev <= prev_mem[rd_addr];
      if (key_we) key_mem[key_wa] <= key_wd;
      if (nx2_we) next_mem[nx2_wa] <= nx2_wd;
      if (nx_we)  next_mem[nx_wa] <= nx_wd;
      if (pv2_we) prev_mem[pv2_wa] <= pv2_wd;
      if (pv_we)  prev_mem[pv_wa] <= pv_wd;
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_ok           = ok_ff;
   assign rsp_result_entry = ResWidth'(res_ff);

   logic acc;
   assign acc = req_valid && req_ready;

   // bucket/free table updates computed alongside
   logic tbl_we;
   logic [LW-1:0] nh, nt, nc, nfh, nft;
   logic f_we;

   always_comb begin
      state_in = state_ff;
      bkt_in = bkt_ff;
      cur_in = cur_ff;
      cnt_in = cnt_ff;
      ok_in = ok_ff;
      res_in = res_ff;
      rd_addr = cur_ff[IW-1:0];
      key_we = 1'b0; key_wa = ent_ff[IW-1:0]; key_wd = key_ff;
      nx_we = 1'b0; nx_wa = ent_ff[IW-1:0]; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = ent_ff[IW-1:0]; pv_wd = NIL;
      nx2_we = 1'b0; nx2_wa = '0; nx2_wd = NIL;
      pv2_we = 1'b0; pv2_wa = '0; pv2_wd = NIL;
      tbl_we = 1'b0;
      nh = bhead_ff[bkt_ff]; nt = btail_ff[bkt_ff]; nc = bcnt_ff[bkt_ff];
      f_we = 1'b0; nfh = fhead_ff; nft = ftail_ff;
      case (state_ff)
         ST_CLEAR: begin
            key_we = 1'b1; key_wa = clr_ff[IW-1:0]; key_wd = '0;
            nx_we = 1'b1; nx_wa = clr_ff[IW-1:0];
            pv_we = 1'b1; pv_wa = clr_ff[IW-1:0];
            if (clr_ff == NIL - 1'b1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc) begin
               ok_in = 1'b0;
               res_in = NIL;
               bkt_in = bsel(req_key);
               cnt_in = '0;
               cur_in = LW'(req_entry);
               rd_addr = IW'(req_entry);
               case (req_opcode)
                  OP_INS_TAIL, OP_INS_HEAD, OP_PUSH: begin
                     state_in = vix(LW'(req_entry)) ? ST_RD_KEY : ST_DONE;
                  end
                  OP_LOOKUP: begin
                     cur_in = bhead_ff[bsel(req_key)];
                     state_in = ST_WALK_RD;
                  end
                  OP_DELETE: state_in = vix(LW'(req_entry)) ? ST_DEL_RD : ST_DONE;
                  OP_POP:    state_in = vix(ftail_ff) ? ST_POP_RD : ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_KEY: begin
            // commit insert or push (no memory read needed)
            ok_in = 1'b1;
            state_in = ST_DONE;
            if (op_ff == OP_PUSH) begin
               f_we = 1'b1;
               nx_we = 1'b1; pv_we = 1'b1;
               nfh = ent_ff;
               if (!vix(fhead_ff)) begin
                  nft = ent_ff;
               end else begin
                  nx_wd = fhead_ff;
                  pv2_we = 1'b1; pv2_wa = fhead_ff[IW-1:0]; pv2_wd = ent_ff;
               end
            end else begin
               key_we = 1'b1;
               nx_we = 1'b1; pv_we = 1'b1;
               tbl_we = 1'b1;
               if (bcnt_ff[bkt_ff] != NIL) nc = bcnt_ff[bkt_ff] + 1'b1;
               if (bcnt_ff[bkt_ff] == '0) begin
                  nh = ent_ff; nt = ent_ff;
               end else if (op_ff == OP_INS_HEAD) begin
                  nx_wd = bhead_ff[bkt_ff];
                  nh = ent_ff;
                  if (vix(bhead_ff[bkt_ff])) begin
                     pv2_we = 1'b1; pv2_wa = bhead_ff[bkt_ff][IW-1:0]; pv2_wd = ent_ff;
                  end
               end else begin
                  pv_wd = btail_ff[bkt_ff];
                  nt = ent_ff;
                  if (vix(btail_ff[bkt_ff])) begin
                     nx2_we = 1'b1; nx2_wa = btail_ff[bkt_ff][IW-1:0]; nx2_wd = ent_ff;
                  end
               end
            end
         end
         ST_DEL_RD: begin
            // key of entry now on rd_key; start walk at its bucket
            bkt_in = bsel(rd_key);
            cur_in = bhead_ff[bsel(rd_key)];
            state_in = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            if (cnt_ff >= bcnt_ff[bkt_ff] || !vix(cur_ff)) begin
               state_in = ST_DONE;
            end else if (op_ff == OP_DELETE && cur_ff == ent_ff) begin
               rd_addr = ent_ff[IW-1:0];
               state_in = ST_DEL_FIX;
            end else begin
               state_in = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (op_ff == OP_LOOKUP && rd_key == key_ff) begin
               ok_in = 1'b1;
               res_in = cur_ff;
               state_in = ST_DONE;
            end else begin
               cur_in = rd_next;
               cnt_in = cnt_ff + 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         ST_DEL_FIX: begin
            ok_in = 1'b1;
            state_in = ST_DONE;
            tbl_we = 1'b1;
            nx_we = 1'b1; pv_we = 1'b1;
            if (bhead_ff[bkt_ff] == ent_ff) nh = rd_next;
            else if (vix(rd_prev)) begin
               nx2_we = 1'b1; nx2_wa = rd_prev[IW-1:0]; nx2_wd = rd_next;
            end
            if (btail_ff[bkt_ff] == ent_ff) nt = rd_prev;
            else if (vix(rd_next)) begin
               pv2_we = 1'b1; pv2_wa = rd_next[IW-1:0]; pv2_wd = rd_prev;
            end
            nc = bcnt_ff[bkt_ff] - 1'b1;
            if (nc == '0) begin
               nh = NIL; nt = NIL;
            end
         end
         ST_POP_RD: begin
            ok_in = 1'b1;
            res_in = ftail_ff;
            state_in = ST_DONE;
            f_we = 1'b1;
            if (fhead_ff == ftail_ff || !vix(rd_prev)) begin
               nfh = NIL; nft = NIL;
            end else begin
               nft = rd_prev;
               nx2_we = 1'b1; nx2_wa = rd_prev[IW-1:0]; nx2_wd = NIL;
            end
         end
         ST_DONE: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_POP_RD || state_ff == ST_IDLE) begin
         // pop reads tail entry; set address on accept
         if (state_ff == ST_IDLE && acc && req_opcode == OP_POP) rd_addr = ftail_ff[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         fhead_ff <= NIL;
         ftail_ff <= NIL;
         for (int i = 0; i < BUCKETS; i++) begin
            bhead_ff[i] <= NIL;
            btail_ff[i] <= NIL;
            bcnt_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (tbl_we) begin
            bhead_ff[bkt_ff] <= nh;
            btail_ff[bkt_ff] <= nt;
            bcnt_ff[bkt_ff]  <= nc;
         end
         if (f_we) begin
            fhead_ff <= nfh;
            ftail_ff <= nft;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bkt_ff <= bkt_in;
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      ok_ff  <= ok_in;
      res_ff <= res_in;
      if (acc) begin
         op_ff  <= opcode_type'(req_opcode);
         ent_ff <= LW'(req_entry);
         key_ff <= req_key;
      end
   end

endmodule
